/* rtl/object_file_block_loader_assert.svh */
// Assertion macros shared by the loader checker.
// Depends on nothing; the including scope provides clk and rst.
`ifndef OBJECT_FILE_BLOCK_LOADER_ASSERT_SVH
`define OBJECT_FILE_BLOCK_LOADER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OFBL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("loader assertion failed");

// Next-cycle implication, disabled during reset.
`define OFBL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("loader assertion failed");

`endif

/* rtl/ofbl_pkg.sv */
// Shared constants and types for the object file block loader.
// Used by the parser core, the top level and the checker.
package ofbl_pkg;

  // Default parameter values.
  localparam int DEF_ADDR_BITS      = 16;
  localparam int DEF_MIN_FILE_BYTES = 7;

  // Fixed field widths of the result item.
  localparam int OUT_ADDR_W = 16;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int PHASE_W    = 3;

  // Parse phases.
  localparam logic [PHASE_W-1:0] PH_MAGIC_HI = 3'd0;
  localparam logic [PHASE_W-1:0] PH_MAGIC_LO = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ADDR_HI  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ADDR_LO  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_COUNT_HI = 3'd4;
  localparam logic [PHASE_W-1:0] PH_COUNT_LO = 3'd5;
  localparam logic [PHASE_W-1:0] PH_DATA     = 3'd6;
  localparam logic [PHASE_W-1:0] PH_SKIP     = 3'd7;

  // Load status codes.
  localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_OBJ = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CORRUPT = 2'd3;

  // Stream packing: output and input tdata widths.
  localparam int TDATA_OUT_W = 64;
  localparam int TDATA_IN_W  = 8;

  // One result item as produced by the parser core.
  typedef struct packed {
    logic                  write_valid;
    logic [OUT_ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0]     write_data;
    logic                  file_done;
    logic [STATUS_W-1:0]   load_status;
    logic [OUT_ADDR_W-1:0] lowest_address;
    logic [OUT_ADDR_W-1:0] highest_address;
  } ofbl_result_t;

endpackage

/* rtl/ofbl_core.sv */
// Parser core: holds the file parse state and computes one result per byte.
// Depends on ofbl_pkg.
module ofbl_core
  import ofbl_pkg::*;
#(
  parameter int ADDR_BITS      = DEF_ADDR_BITS,
  parameter int MIN_FILE_BYTES = DEF_MIN_FILE_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [BYTE_W-1:0]  byte_value,
  input  logic               last_byte,
  input  logic [WORD_W-1:0]  magic_word,
  output ofbl_result_t       result
);

  localparam int SEEN_W = $clog2(MIN_FILE_BYTES + 1);
  localparam int EXT_W  = (ADDR_BITS > OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;
  localparam int WEXT_W = (ADDR_BITS > WORD_W) ? ADDR_BITS : WORD_W;
  localparam logic [SEEN_W-1:0]    SEEN_MAX = SEEN_W'(MIN_FILE_BYTES);
  localparam logic [ADDR_BITS-1:0] ADDR_ONES = '1;

  // State registers.
  logic [PHASE_W-1:0]   parse_phase,     parse_phase_next;
  logic [SEEN_W-1:0]    bytes_seen,      bytes_seen_next;
  logic [BYTE_W-1:0]    held_high_byte,  held_high_byte_next;
  logic [ADDR_BITS-1:0] block_address,   block_address_next;
  logic [WORD_W-1:0]    bytes_remaining, bytes_remaining_next;
  logic                 bad_magic_seen,  bad_magic_seen_next;
  logic [ADDR_BITS-1:0] min_seen,        min_seen_next;
  logic [ADDR_BITS-1:0] max_seen,        max_seen_next;

  logic [WORD_W-1:0]    word;
  logic [WEXT_W-1:0]    word_ext;
  logic [WORD_W-1:0]    remaining_dec;
  logic                 overrun;
  logic                 wv;
  logic [ADDR_BITS-1:0] waddr;
  logic [STATUS_W-1:0]  status;
  logic [EXT_W-1:0]     waddr_ext;
  logic [EXT_W-1:0]     min_ext;
  logic [EXT_W-1:0]     max_ext;

  assign word          = {held_high_byte, byte_value};
  assign word_ext      = WEXT_W'(word);
  assign remaining_dec = bytes_remaining - 1'b1;

  // Phase walk and state update for one byte.
  always_comb begin
    parse_phase_next     = parse_phase;
    held_high_byte_next  = held_high_byte;
    block_address_next   = block_address;
    bytes_remaining_next = bytes_remaining;
    bad_magic_seen_next  = bad_magic_seen;
    min_seen_next        = min_seen;
    max_seen_next        = max_seen;
    overrun              = 1'b0;
    wv                   = 1'b0;
    waddr                = '0;

    if (bytes_seen < SEEN_MAX) begin
      bytes_seen_next = bytes_seen + 1'b1;
    end else begin
      bytes_seen_next = bytes_seen;
    end

    case (parse_phase)
      PH_MAGIC_HI, PH_ADDR_HI, PH_COUNT_HI: begin
        held_high_byte_next = byte_value;
        parse_phase_next    = parse_phase + 1'b1;
      end
      PH_MAGIC_LO: begin
        if (word != magic_word) begin
          bad_magic_seen_next = 1'b1;
          parse_phase_next    = PH_SKIP;
        end else begin
          parse_phase_next    = PH_ADDR_HI;
        end
      end
      PH_ADDR_LO: begin
        block_address_next = word_ext[ADDR_BITS-1:0];
        parse_phase_next   = PH_COUNT_HI;
      end
      PH_COUNT_LO: begin
        bytes_remaining_next = word;
        if (block_address < min_seen) begin
          min_seen_next = block_address;
        end
        if (word == '0) begin
          parse_phase_next = PH_ADDR_HI;
        end else begin
          parse_phase_next = PH_DATA;
          overrun          = 1'b1;
        end
      end
      PH_DATA: begin
        wv    = 1'b1;
        waddr = block_address;
        if (block_address > max_seen) begin
          max_seen_next = block_address;
        end
        block_address_next   = block_address + 1'b1;
        bytes_remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          parse_phase_next = PH_ADDR_HI;
        end else begin
          overrun = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Final status, reported only on the last byte.
    if (!last_byte) begin
      status = ST_BUSY;
    end else if (bytes_seen_next < SEEN_MAX || bad_magic_seen_next) begin
      status = ST_NOT_OBJ;
    end else if (overrun) begin
      status = ST_CORRUPT;
    end else begin
      status = ST_OK;
    end
  end

  // Result fields, addresses brought to the fixed output width.
  assign waddr_ext = EXT_W'(waddr);
  assign min_ext   = EXT_W'(min_seen_next);
  assign max_ext   = EXT_W'(max_seen_next);

  always_comb begin
    result.write_valid     = wv;
    result.write_address   = waddr_ext[OUT_ADDR_W-1:0];
    result.write_data      = wv ? byte_value : '0;
    result.file_done       = last_byte;
    result.load_status     = status;
    result.lowest_address  = min_ext[OUT_ADDR_W-1:0];
    result.highest_address = max_ext[OUT_ADDR_W-1:0];
  end

  // State registers; the last byte of a file returns them to reset values.
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      parse_phase     <= PH_MAGIC_HI;
      bytes_seen      <= '0;
      held_high_byte  <= '0;
      block_address   <= '0;
      bytes_remaining <= '0;
      bad_magic_seen  <= 1'b0;
      min_seen        <= ADDR_ONES;
      max_seen        <= '0;
    end else if (step) begin
      parse_phase     <= parse_phase_next;
      bytes_seen      <= bytes_seen_next;
      held_high_byte  <= held_high_byte_next;
      block_address   <= block_address_next;
      bytes_remaining <= bytes_remaining_next;
      bad_magic_seen  <= bad_magic_seen_next;
      min_seen        <= min_seen_next;
      max_seen        <= max_seen_next;
    end
  end

endmodule

/* rtl/object_file_block_loader.sv */
// Object file block loader: parses a byte stream into memory writes.
// Each input byte passes through the input register and then the result register.
// Throughput: one byte per cycle while the master side accepts results, set by the single parser step per byte.
// Reset (rst, synchronous): clears the parse state and sets magic_word to 0.
// Each last byte also returns the parse state to its reset values.
// Depends on ofbl_pkg and ofbl_core.
module object_file_block_loader
  import ofbl_pkg::*;
#(
  parameter int ADDR_BITS      = DEF_ADDR_BITS,
  parameter int MIN_FILE_BYTES = DEF_MIN_FILE_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration: magic_word.
  input  logic                   cfg_wr_en,
  input  logic [WORD_W-1:0]      cfg_wr_data,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic                   s_axis_tlast,   // last_byte
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] write_address, [23:16] write_data, [25:24] load_status,
  // [41:26] lowest_address, [57:42] highest_address, [63:58] zero
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,   // file_done
  output logic [0:0]             m_axis_tuser    // write_valid
);

  localparam int PAD_W = TDATA_OUT_W - (3 * OUT_ADDR_W + BYTE_W + STATUS_W);

  logic [WORD_W-1:0] magic_word;
  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;
  logic              stage_last;
  logic              advance;
  ofbl_result_t      result;
  ofbl_result_t      out_item;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= '0;
    end else if (cfg_wr_en) begin
      magic_word <= cfg_wr_data;
    end
  end

  // The stage moves on when the result register is empty or being drained.
  assign advance       = stage_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !stage_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_axis_tready) begin
      stage_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stage_byte <= s_axis_tdata[BYTE_W-1:0];
      stage_last <= s_axis_tlast;
    end
  end

  // Parser core.
  ofbl_core #(
    .ADDR_BITS      (ADDR_BITS),
    .MIN_FILE_BYTES (MIN_FILE_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .byte_value (stage_byte),
    .last_byte  (stage_last),
    .magic_word (magic_word),
    .result     (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  // Output packing.
  assign m_axis_tdata = {{PAD_W{1'b0}},
                         out_item.highest_address,
                         out_item.lowest_address,
                         out_item.load_status,
                         out_item.write_data,
                         out_item.write_address};
  assign m_axis_tlast = out_item.file_done;
  assign m_axis_tuser = out_item.write_valid;

endmodule

/* rtl/ofbl_checker.sv */
// Port-level checks for the object file block loader, bound to the top level.
// Depends on ofbl_pkg and object_file_block_loader_assert.svh.
`include "object_file_block_loader_assert.svh"

module ofbl_checker
  import ofbl_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [TDATA_OUT_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic [0:0]             m_axis_tuser
);

  logic [STATUS_W-1:0] status;
  assign status = m_axis_tdata[25:24];

  // A status is only reported with the last byte of a file.
  `OFBL_ASSERT_IMP(a_status_only_last, m_axis_tvalid && !m_axis_tlast, status == ST_BUSY)

  // The last byte always carries a final status.
  `OFBL_ASSERT_IMP(a_last_has_status, m_axis_tvalid && m_axis_tlast, status != ST_BUSY)

  // A result without a write carries zero address and data.
  `OFBL_ASSERT_IMP(a_idle_write_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[23:0] == '0)

  // A stalled result holds its payload.
  `OFBL_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind object_file_block_loader ofbl_checker u_ofbl_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
